FILE: rtl/core/i2cps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cps_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WMSB  = 3'd3,
		CMD_WLSB  = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	localparam logic [5:0] WRITE_BIT_PHASES = 6'd24;
	localparam logic [5:0] WRITE_LAST_PHASE = 6'd27;
	localparam logic [5:0] READ_LAST_PHASE  = 6'd31;

	// phase position inside a four-phase sample slot
	localparam logic [1:0] SLOT_REL_SDA = 2'd0;
	localparam logic [1:0] SLOT_REL_SCL = 2'd1;
	localparam logic [1:0] SLOT_SAMPLE  = 2'd2;

	typedef struct packed {
		cmd_t       cmd;
		logic [5:0] phase;
		logic [1:0] sub;    // phase mod 3 while shifting out a write byte
		logic [7:0] shift;
		logic       scl;
		logic       sda;
		logic       ack;
	} state_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy;
		logic       done;
		logic       start_failed;
		logic       ack_bit;
		logic [7:0] read_data;
	} result_t;

	localparam state_t STATE_RESET = '{
		cmd:   CMD_IDLE,
		phase: 6'd0,
		sub:   2'd0,
		shift: 8'd0,
		scl:   1'b1,
		sda:   1'b1,
		ack:   1'b0
	};

endpackage

`default_nettype wire

FILE: rtl/core/i2cps_step.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cps_step (
	input  wire i2cps_pkg::state_t st_cur,
	input  wire logic [2:0]        kind,
	input  wire logic [7:0]        write_data,
	input  wire logic              sda_in,
	input  wire logic              scl_in,
	output i2cps_pkg::state_t      st_nxt,
	output i2cps_pkg::result_t     res
);
	import i2cps_pkg::*;

	state_t     st;
	logic       done;
	logic       failed;
	logic [5:0] p;

	always_comb begin
		st        = st_cur;
		done      = 1'b0;
		failed    = 1'b0;
		res       = '0;

		if (st_cur.cmd == CMD_IDLE && kind inside {[CMD_START:CMD_READ]}) begin
			st.cmd    = cmd_t'(kind);
			st.phase  = 6'd0;
			st.sub    = 2'd0;
			if (kind == CMD_WMSB || kind == CMD_WLSB) begin
				st.shift = write_data;
			end else if (kind == CMD_READ) begin
				st.shift = 8'd0;
			end
		end
		p = st.phase;

		case (st.cmd)
			CMD_START: begin
				if (p == 6'd0) begin
					st.sda = 1'b1;
				end else if (p == 6'd1) begin
					st.scl = 1'b1;
				end else if (p == 6'd2) begin
					if (sda_in && scl_in) begin
						st.sda = 1'b0;
					end else begin
						failed = 1'b1;
						done   = 1'b1;
					end
				end else begin
					st.scl = 1'b0;
					done   = 1'b1;
				end
			end
			CMD_STOP: begin
				if (p == 6'd0) begin
					st.scl = 1'b0;
				end else if (p == 6'd1) begin
					st.sda = 1'b0;
				end else if (p == 6'd2) begin
					st.scl = 1'b1;
				end else begin
					st.sda = 1'b1;
					done   = 1'b1;
				end
			end
			CMD_WMSB, CMD_WLSB: begin
				if (p < WRITE_BIT_PHASES) begin
					case (st.sub)
						2'd0: begin
							if (st.cmd == CMD_WMSB) begin
								st.sda   = st.shift[7];
								st.shift = {st.shift[6:0], 1'b0};
							end else begin
								st.sda   = st.shift[0];
								st.shift = {1'b0, st.shift[7:1]};
							end
						end
						2'd1:    st.scl = 1'b1;
						default: st.scl = 1'b0;
					endcase
					st.sub = (st.sub == 2'd2) ? 2'd0 : st.sub + 2'd1;
				end else begin
					// ack slot; 24 is a multiple of 4 so p[1:0] is the slot position
					case (p[1:0])
						SLOT_REL_SDA: st.sda = 1'b1;
						SLOT_REL_SCL: st.scl = 1'b1;
						SLOT_SAMPLE:  st.ack = sda_in;
						default:      st.scl = 1'b0;
					endcase
					if (p >= WRITE_LAST_PHASE) begin
						done = 1'b1;
					end
				end
			end
			CMD_READ: begin
				case (p[1:0])
					SLOT_REL_SDA: st.sda = 1'b1;
					SLOT_REL_SCL: st.scl = 1'b1;
					SLOT_SAMPLE:  st.shift[p[4:2]] = st.shift[p[4:2]] | sda_in;
					default:      st.scl = 1'b0;
				endcase
				if (p >= READ_LAST_PHASE) begin
					done          = 1'b1;
					res.read_data = st.shift;
				end
			end
			default: st.cmd = CMD_IDLE;
		endcase

		if (st.cmd != CMD_IDLE) begin
			if (done) begin
				st.cmd   = CMD_IDLE;
				st.phase = 6'd0;
			end else begin
				st.phase = st.phase + 6'd1;
			end
		end

		st_nxt           = st;
		res.scl_drive    = st.scl;
		res.sda_drive    = st.sda;
		res.busy         = (st.cmd != CMD_IDLE);
		res.done         = done;
		res.start_failed = failed;
		res.ack_bit      = st.ack;
	end

endmodule

`default_nettype wire

FILE: rtl/core/i2c_master_phase_sequencer_core.sv
// I2C master phase sequencer core.
// Input channel (in_valid/in_ready): one request per bus phase tick, carrying
// kind, write_data and the sampled sda_in/scl_in levels. kind is looked at
// only while no command runs; 1 start, 2 stop, 3/4 write MSB/LSB first,
// 5 read, anything else is a plain tick.
// Output channel (out_valid/out_ready): exactly one result per request with
// the line drives after that phase, busy/done flags, start_failed, the latest
// write ACK and the byte assembled by a read (zero except on its last phase).
// A request taken into the input register moves into the result register
// once that one is empty or being taken. Throughput: one request per cycle
// while out_ready is high; the phase state is updated as a request moves
// from the input register into the result register, so back-to-back
// requests see each other's state. When out_ready is low the result register
// holds and the input register still takes one more request; in_ready is
// low while both are full and out_ready is low.
// Reset (arst_n low): both registers empty, no command running, SCL and SDA
// levels in the phase state released, ACK and shift byte cleared.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_phase_sequencer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] kind,
	input  wire logic [7:0] write_data,
	input  wire logic       sda_in,
	input  wire logic       scl_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            scl_drive,
	output logic            sda_drive,
	output logic            busy_res,
	output logic            done_res,
	output logic            start_failed,
	output logic            ack_bit,
	output logic [7:0]      read_data
);
	import i2cps_pkg::*;

	logic       valid_s1;
	logic [2:0] kind_s1;
	logic [7:0] wdata_s1;
	logic       sda_s1;
	logic       scl_s1;

	logic       valid_s2;
	result_t    res_s2;

	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	i2cps_step u_step (
		.st_cur     (state_q),
		.kind       (kind_s1),
		.write_data (wdata_s1),
		.sda_in     (sda_s1),
		.scl_in     (scl_s1),
		.st_nxt     (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			wdata_s1 <= write_data;
			sda_s1   <= sda_in;
			scl_s1   <= scl_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_RESET;
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				res_s2   <= res_nxt;
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign scl_drive    = res_s2.scl_drive;
	assign sda_drive    = res_s2.sda_drive;
	assign busy_res     = res_s2.busy;
	assign done_res     = res_s2.done;
	assign start_failed = res_s2.start_failed;
	assign ack_bit      = res_s2.ack_bit;
	assign read_data    = res_s2.read_data;

endmodule

`default_nettype wire

FILE: rtl/core/i2cps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       scl_drive,
	input wire logic       sda_drive,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic       start_failed,
	input wire logic       ack_bit,
	input wire logic [7:0] read_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(done_res) && $stable(busy_res) && $stable(ack_bit))
		else $error("stalled result changed");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("finished command still busy");

	a_fail_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_failed |-> done_res && scl_drive && sda_drive)
		else $error("start failure outside a finishing tick");

	a_rdata_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 8'd0 |-> done_res)
		else $error("read data outside a finishing tick");

	// with the result side free the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready && $past(out_ready) |-> in_ready)
		else $error("input stalled with output free");

endmodule

bind i2c_master_phase_sequencer_core i2cps_checker u_i2cps_checker (.*);

`default_nettype wire

FILE: tb/tb_i2c_master_phase_sequencer_core.sv
`timescale 1ns / 1ps

module tb_i2c_master_phase_sequencer_core;
	import i2cps_pkg::*;

	localparam logic [2:0] KIND_TICK      = 3'd0;
	localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

	localparam int RAND_ITEMS = 1344;
	localparam int DIR_ROWS   = 18;

	// out_ready patterns
	localparam int SINK_FREE   = 0;
	localparam int SINK_COIN   = 1;
	localparam int SINK_EVERY4 = 2;
	localparam int SINK_MOSTLY = 3;

	localparam result_t RES_NONE       = '0;
	localparam result_t RES_IDLE       = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
	localparam result_t RES_START_FAIL = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00};

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] wdata;
		logic       sda;
		logic       scl;
		logic [7:0] reps;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] kind;
	logic [7:0] write_data;
	logic       sda_in;
	logic       scl_in;
	logic       out_valid;
	logic       out_ready;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic       start_failed;
	logic       ack_bit;
	logic [7:0] read_data;

	// bus sequencer model state
	cmd_t       bus_cmd;
	logic [5:0] bus_phase;
	logic [7:0] shreg;
	logic       scl_lvl;
	logic       sda_lvl;
	logic       ack_lvl;

	result_t     phase_results_q[$];
	result_t     head;
	dir_row_t    dir_tab [DIR_ROWS];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned requests_sent;
	int unsigned input_stalls;
	int unsigned start_fails;
	int unsigned launched [8];

	i2c_master_phase_sequencer_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.write_data  (write_data),
		.sda_in      (sda_in),
		.scl_in      (scl_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_drive   (scl_drive),
		.sda_drive   (sda_drive),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.start_failed(start_failed),
		.ack_bit     (ack_bit),
		.read_data   (read_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("i2c_master_phase_sequencer_core regression: fail");
		$finish;
	end

	// release / release / sample / pull-low slot shared by ACK and read bits
	function automatic logic sample_slot(logic [1:0] slot);
		case (slot)
			SLOT_REL_SDA: sda_lvl = 1'b1;
			SLOT_REL_SCL: scl_lvl = 1'b1;
			SLOT_SAMPLE:  return 1'b1;
			default:      scl_lvl = 1'b0;
		endcase
		return 1'b0;
	endfunction

	function automatic result_t next_bus_phase(logic [2:0] k, logic [7:0] wd, logic sda,
			logic scl);
		result_t    r;
		logic [5:0] p;
		logic [5:0] ack_pos;
		logic       fin;
		logic       fail;
		logic [7:0] rd;
		fin  = 1'b0;
		fail = 1'b0;
		rd   = 8'h00;
		if (bus_cmd == CMD_IDLE && k >= CMD_START && k <= CMD_READ) begin
			bus_cmd   = cmd_t'(k);
			bus_phase = 6'd0;
			if (k == CMD_WMSB || k == CMD_WLSB)
				shreg = wd;
			else if (k == CMD_READ)
				shreg = 8'h00;
		end
		p = bus_phase;
		case (bus_cmd)
			CMD_START: begin
				if (p == 6'd0) begin
					sda_lvl = 1'b1;
				end else if (p == 6'd1) begin
					scl_lvl = 1'b1;
				end else if (p == 6'd2) begin
					if (sda && scl) begin
						sda_lvl = 1'b0;
					end else begin
						fail = 1'b1;
						fin  = 1'b1;
					end
				end else begin
					scl_lvl = 1'b0;
					fin     = 1'b1;
				end
			end
			CMD_STOP: begin
				if (p == 6'd0)
					scl_lvl = 1'b0;
				else if (p == 6'd1)
					sda_lvl = 1'b0;
				else if (p == 6'd2)
					scl_lvl = 1'b1;
				else begin
					sda_lvl = 1'b1;
					fin     = 1'b1;
				end
			end
			CMD_WMSB, CMD_WLSB: begin
				if (p < WRITE_BIT_PHASES) begin
					case (p % 6'd3)
						6'd0: begin
							if (bus_cmd == CMD_WMSB) begin
								sda_lvl = shreg[7];
								shreg   = shreg << 1;
							end else begin
								sda_lvl = shreg[0];
								shreg   = shreg >> 1;
							end
						end
						6'd1:    scl_lvl = 1'b1;
						default: scl_lvl = 1'b0;
					endcase
				end else begin
					ack_pos = p - WRITE_BIT_PHASES;
					if (sample_slot(ack_pos[1:0]))
						ack_lvl = sda;
					if (p >= WRITE_LAST_PHASE)
						fin = 1'b1;
				end
			end
			CMD_READ: begin
				if (sample_slot(p[1:0]))
					shreg[p[4:2]] = sda;
				if (p >= READ_LAST_PHASE) begin
					fin = 1'b1;
					rd  = shreg;
				end
			end
			default: ;
		endcase
		if (bus_cmd != CMD_IDLE) begin
			if (fin) begin
				bus_cmd   = CMD_IDLE;
				bus_phase = 6'd0;
			end else begin
				bus_phase = bus_phase + 6'd1;
			end
		end
		r.scl_drive    = scl_lvl;
		r.sda_drive    = sda_lvl;
		r.busy         = (bus_cmd != CMD_IDLE);
		r.done         = fin;
		r.start_failed = fail;
		r.ack_bit      = ack_lvl;
		r.read_data    = rd;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
		$display("[%0t] result %0d: %s got %0h, expected %0h", $time, results_seen, field,
			got, want);
		mismatches++;
	endtask

	// one request per call; in_valid stays high if the next call follows directly
	task automatic send_request(logic [2:0] k, logic [7:0] wd, logic s_da, logic s_cl,
			logic typed, result_t want);
		result_t pred;
		@(negedge clk);
		in_valid   <= 1'b1;
		kind       <= k;
		write_data <= wd;
		sda_in     <= s_da;
		scl_in     <= s_cl;
		@(posedge clk);
		while (!in_ready) begin
			input_stalls++;
			@(posedge clk);
		end
		if (bus_cmd == CMD_IDLE && k >= CMD_START && k <= CMD_READ)
			launched[k]++;
		pred = next_bus_phase(k, wd, s_da, s_cl);
		if (pred.start_failed)
			start_fails++;
		phase_results_q.push_back(typed ? want : pred);
		requests_sent++;
	endtask

	task automatic idle_gap(int unsigned n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (phase_results_q.size() == 0) begin
				report_mismatch("unrequested result, scl_drive", 8'(scl_drive), 8'h00);
			end else begin
				head = phase_results_q.pop_front();
				if (scl_drive !== head.scl_drive)
					report_mismatch("scl_drive", 8'(scl_drive), 8'(head.scl_drive));
				if (sda_drive !== head.sda_drive)
					report_mismatch("sda_drive", 8'(sda_drive), 8'(head.sda_drive));
				if (busy_res !== head.busy)
					report_mismatch("busy_res", 8'(busy_res), 8'(head.busy));
				if (done_res !== head.done)
					report_mismatch("done_res", 8'(done_res), 8'(head.done));
				if (start_failed !== head.start_failed)
					report_mismatch("start_failed", 8'(start_failed),
						8'(head.start_failed));
				if (ack_bit !== head.ack_bit)
					report_mismatch("ack_bit", 8'(ack_bit), 8'(head.ack_bit));
				if (read_data !== head.read_data)
					report_mismatch("read_data", read_data, head.read_data);
			end
			results_seen++;
		end
	end

	// receiver: changing stall patterns plus a periodic long hold-off
	initial begin : sink
		int unsigned cyc;
		int unsigned hold_left;
		int unsigned mode_left;
		int          mode;
		cyc       = 0;
		hold_left = 0;
		mode_left = 0;
		mode      = SINK_FREE;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_left == 0 && cyc % 3000 == 1200)
				hold_left = 150;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = int'($urandom_range(SINK_FREE, SINK_MOSTLY));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					SINK_FREE:   out_ready <= 1'b1;
					SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
					SINK_EVERY4: out_ready <= (cyc % 4 == 0);
					default:     out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin : source
		int unsigned burst_left;
		int unsigned gap;
		logic [2:0]  k;
		logic [7:0]  wd;
		logic        s_da;
		logic        s_cl;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_TICK;
		write_data    = 8'h00;
		sda_in        = 1'b1;
		scl_in        = 1'b1;
		bus_cmd       = CMD_IDLE;
		bus_phase     = 6'd0;
		shreg         = 8'h00;
		scl_lvl       = 1'b1;
		sda_lvl       = 1'b1;
		ack_lvl       = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
		requests_sent = 0;
		input_stalls  = 0;
		start_fails   = 0;
		burst_left    = 0;
		foreach (launched[i])
			launched[i] = 0;
		// kind, data, sda, scl, repeat, typed, expected
		dir_tab = '{
			'{KIND_TICK,      8'h00, 1'b0, 1'b0, 8'd1,  1'b1, RES_IDLE},
			'{KIND_UNUSED_LO, 8'hFF, 1'b1, 1'b1, 8'd1,  1'b1, RES_IDLE},
			'{KIND_UNUSED_HI, 8'h00, 1'b0, 1'b1, 8'd1,  1'b1, RES_IDLE},
			// start on a free bus; commands offered while busy are dropped
			'{CMD_START,      8'h00, 1'b1, 1'b1, 8'd1,  1'b0, RES_NONE},
			'{CMD_STOP,       8'h00, 1'b1, 1'b1, 8'd3,  1'b0, RES_NONE},
			// start with SDA held low elsewhere
			'{CMD_START,      8'h00, 1'b1, 1'b1, 8'd2,  1'b0, RES_NONE},
			'{KIND_TICK,      8'h00, 1'b0, 1'b1, 8'd1,  1'b1, RES_START_FAIL},
			// start with SCL stretched low
			'{CMD_START,      8'hFF, 1'b1, 1'b1, 8'd2,  1'b0, RES_NONE},
			'{KIND_TICK,      8'hFF, 1'b1, 1'b0, 8'd1,  1'b1, RES_START_FAIL},
			'{CMD_STOP,       8'h00, 1'b0, 1'b0, 8'd1,  1'b0, RES_NONE},
			'{CMD_READ,       8'h00, 1'b0, 1'b0, 8'd3,  1'b0, RES_NONE},
			// all-ones MSB first, slave ACKs
			'{CMD_WMSB,       8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, RES_NONE},
			'{CMD_WLSB,       8'h00, 1'b0, 1'b1, 8'd27, 1'b0, RES_NONE},
			// all-zeros LSB first, slave NACKs
			'{CMD_WLSB,       8'h00, 1'b1, 1'b1, 8'd1,  1'b0, RES_NONE},
			'{CMD_WMSB,       8'hFF, 1'b1, 1'b1, 8'd27, 1'b0, RES_NONE},
			// read with SDA high throughout
			'{CMD_READ,       8'h00, 1'b1, 1'b1, 8'd1,  1'b0, RES_NONE},
			'{CMD_START,      8'hFF, 1'b1, 1'b0, 8'd31, 1'b0, RES_NONE},
			'{KIND_TICK,      8'h5A, 1'b0, 1'b0, 8'd1,  1'b0, RES_NONE}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_tab[i])
			repeat (dir_tab[i].reps)
				send_request(dir_tab[i].kind, dir_tab[i].wdata, dir_tab[i].sda,
					dir_tab[i].scl, dir_tab[i].typed, dir_tab[i].want);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				idle_gap(1);
				while (phase_results_q.size() != 0)
					@(posedge clk);
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
				if (gap != 0)
					idle_gap(gap);
			end
			burst_left--;
			wd   = 8'($urandom_range(0, 255));
			s_da = 1'($urandom_range(0, 1));
			s_cl = 1'($urandom_range(0, 1));
			if (bus_cmd == CMD_IDLE && $urandom_range(0, 99) < 82)
				k = 3'($urandom_range(int'(CMD_START), int'(CMD_READ)));
			else
				k = 3'($urandom_range(0, 7));
			// mostly give the start check a free bus
			if (bus_cmd == CMD_START && bus_phase == 6'd2 && $urandom_range(0, 3) != 0) begin
				s_da = 1'b1;
				s_cl = 1'b1;
			end
			send_request(k, wd, s_da, s_cl, 1'b0, RES_NONE);
		end

		idle_gap(1);
		while (phase_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d results checked, %0d cycles of input backpressure",
			requests_sent, results_seen, input_stalls);
		$display("commands: %0d start (%0d bus not free), %0d stop, %0d write, %0d read",
			launched[CMD_START], start_fails, launched[CMD_STOP],
			launched[CMD_WMSB] + launched[CMD_WLSB], launched[CMD_READ]);
		if (mismatches == 0)
			$display("i2c_master_phase_sequencer_core regression: pass");
		else
			$display("i2c_master_phase_sequencer_core regression: fail");
		$finish;
	end

endmodule
